// ----- hdl/bfw_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the byte FIFO with watermarks.
// Used by bfw_ctrl, bfw_datapath and byte_fifo_with_watermarks; no dependencies.
package bfw_pkg;

	// Store geometry
	localparam int Depth = 64;
	localparam int AddrW = $clog2(Depth);
	localparam int SizeW = $clog2(Depth + 1);
	localparam int CmpW  = (SizeW > 7) ? SizeW : 7;

	// Configuration register
	localparam int          RingSizeW     = 7;
	localparam logic [6:0]  RingSizeReset = 7'd64;
	localparam int          MinRing       = 3;
	localparam logic        RegRingSize   = 1'b0;

	localparam logic [7:0]  NewlineByte   = 8'h0A;

	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_POP   = 2'd1,
		REQ_PEEK  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP_LOAD,
		ST_EMIT,
		ST_PEEK
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic push;
		logic pop;
		logic peek_none;
		logic peek_start;
		logic clear;
		logic load_oldest;
		logic emit_single;
		logic emit_peek;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic count_zero;
		logic peek_none;
		logic peek_last;
		logic out_free;
	} status_t;

endpackage

// ----- hdl/bfw_ctrl.sv -----
`timescale 1ns / 1ps
// Request sequencer of the byte FIFO: accepts one request at a time and steps the datapath.
// Depends on bfw_pkg.
module bfw_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        req_type,
	input  bfw_pkg::status_t  status,
	output logic              in_stall,
	output bfw_pkg::cmd_t     cmd
);

	bfw_pkg::state_t state_q;
	bfw_pkg::state_t state_next;
	bfw_pkg::req_t   req;

	assign req      = bfw_pkg::req_t'(req_type);
	assign in_stall = (state_q != bfw_pkg::ST_IDLE);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfw_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			bfw_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (req)
						bfw_pkg::REQ_POP: begin
							state_next = status.count_zero ? bfw_pkg::ST_EMIT
							                               : bfw_pkg::ST_POP_LOAD;
						end
						bfw_pkg::REQ_PEEK: begin
							state_next = status.peek_none ? bfw_pkg::ST_EMIT
							                              : bfw_pkg::ST_PEEK;
						end
						default: state_next = bfw_pkg::ST_EMIT;
					endcase
				end
			end
			bfw_pkg::ST_POP_LOAD: state_next = bfw_pkg::ST_EMIT;
			bfw_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_next = bfw_pkg::ST_IDLE;
				end
			end
			bfw_pkg::ST_PEEK: begin
				if (status.out_free && status.peek_last) begin
					state_next = bfw_pkg::ST_IDLE;
				end
			end
			default: state_next = bfw_pkg::ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd = '0;
		unique case (state_q)
			bfw_pkg::ST_IDLE: begin
				if (in_valid) begin
					unique case (req)
						bfw_pkg::REQ_PUSH:  cmd.push = 1'b1;
						bfw_pkg::REQ_POP:   cmd.pop = 1'b1;
						bfw_pkg::REQ_PEEK: begin
							cmd.peek_none  = status.peek_none;
							cmd.peek_start = !status.peek_none;
						end
						bfw_pkg::REQ_CLEAR: cmd.clear = 1'b1;
						default: cmd = '0;
					endcase
				end
			end
			bfw_pkg::ST_POP_LOAD: cmd.load_oldest = 1'b1;
			bfw_pkg::ST_EMIT:     cmd.emit_single = status.out_free;
			bfw_pkg::ST_PEEK:     cmd.emit_peek = status.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- hdl/bfw_datapath.sv -----
`timescale 1ns / 1ps
// Byte store, pointers, counters, status flags and result register of the byte FIFO.
// Depends on bfw_pkg; driven by commands from bfw_ctrl.
module bfw_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bfw_pkg::cmd_t               cmd,
	output bfw_pkg::status_t            status,
	input  logic [7:0]                  data_in,
	input  logic [5:0]                  peek_count,
	input  logic                        cfg_wr,
	input  logic [bfw_pkg::RingSizeW-1:0] cfg_ring_size,
	output logic [bfw_pkg::RingSizeW-1:0] ring_size,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic                        accepted,
	output logic [7:0]                  data_out,
	output logic                        data_valid,
	output logic                        last,
	output logic [5:0]                  fill_count,
	output logic                        full_res,
	output logic                        empty_res,
	output logic                        high_water,
	output logic                        low_water,
	output logic                        has_line,
	output logic [7:0]                  oldest_byte,
	output logic [7:0]                  newest_byte
);

	localparam int AddrW = bfw_pkg::AddrW;
	localparam int CmpW  = bfw_pkg::CmpW;

	// Wrap a position inside the active size
	function automatic logic [AddrW-1:0] next_pos(input logic [AddrW-1:0] p,
	                                              input logic [CmpW-1:0] s);
		logic [CmpW-1:0] inc;
		inc = CmpW'(p) + CmpW'(1);
		return (inc >= s) ? '0 : AddrW'(inc);
	endfunction

	logic [7:0]                   mem [bfw_pkg::Depth];
	logic [7:0]                   rd_data_q;
	logic [bfw_pkg::RingSizeW-1:0] ring_size_q;
	logic [AddrW-1:0]             rd_ptr_q;
	logic [AddrW-1:0]             wr_ptr_q;
	logic [AddrW-1:0]             count_q;
	logic [AddrW-1:0]             nl_count_q;
	logic [7:0]                   last_pushed_q;
	logic [7:0]                   oldest_q;
	logic [AddrW-1:0]             peek_ptr_q;
	logic [AddrW-1:0]             remain_q;
	logic                         res_acc_q;
	logic [7:0]                   res_data_q;
	logic                         res_valid_q;
	logic                         out_valid_q;

	logic [CmpW-1:0]              ring_ext;
	logic [CmpW-1:0]              active;
	logic [CmpW-1:0]              count_ext;
	logic [CmpW-1:0]              peek_ext;
	logic [CmpW+1:0]              high_mark;
	logic                         can_push;
	logic                         do_push;
	logic                         do_pop;
	logic                         rd_en;
	logic [AddrW-1:0]             rd_addr;
	logic [AddrW-1:0]             peek_len;
	logic                         load_out;

	// Clamp the configured size into the supported range
	assign ring_ext  = CmpW'(ring_size_q);
	assign active    = (ring_ext < CmpW'(bfw_pkg::MinRing)) ? CmpW'(bfw_pkg::MinRing) :
	                   (ring_ext > CmpW'(bfw_pkg::Depth))   ? CmpW'(bfw_pkg::Depth) : ring_ext;
	assign count_ext = CmpW'(count_q);
	assign peek_ext  = CmpW'(peek_count);
	assign high_mark = ((CmpW + 2)'(active) * (CmpW + 2)'(3)) >> 2;

	assign can_push = (count_ext < (active - CmpW'(1)));
	assign do_push  = cmd.push && can_push;
	assign do_pop   = cmd.pop && (count_q != '0);
	assign peek_len = (peek_ext < count_ext) ? AddrW'(peek_ext) : count_q;
	assign load_out = cmd.emit_single || cmd.emit_peek;

	assign status.count_zero = (count_q == '0);
	assign status.peek_none  = (peek_count == '0) || (count_q == '0);
	assign status.peek_last  = (remain_q == AddrW'(1));
	assign status.out_free   = !out_valid_q || !out_stall;

	assign ring_size = ring_size_q;

	// Read address: head successor on pop, head on peek start, walk pointer afterwards
	always_comb begin
		rd_en   = do_pop || cmd.peek_start || (cmd.emit_peek && !status.peek_last);
		rd_addr = peek_ptr_q;
		if (cmd.pop) begin
			rd_addr = next_pos(rd_ptr_q, active);
		end else if (cmd.peek_start) begin
			rd_addr = rd_ptr_q;
		end
	end

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= data_in;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Pointers and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q   <= bfw_pkg::RingSizeReset;
			rd_ptr_q      <= '0;
			wr_ptr_q      <= '0;
			count_q       <= '0;
			nl_count_q    <= '0;
			last_pushed_q <= '0;
		end else if (cfg_wr) begin
			ring_size_q <= cfg_ring_size;
			rd_ptr_q    <= '0;
			wr_ptr_q    <= '0;
			count_q     <= '0;
			nl_count_q  <= '0;
		end else if (cmd.clear) begin
			rd_ptr_q   <= '0;
			wr_ptr_q   <= '0;
			count_q    <= '0;
			nl_count_q <= '0;
		end else if (do_push) begin
			wr_ptr_q      <= next_pos(wr_ptr_q, active);
			count_q       <= count_q + AddrW'(1);
			last_pushed_q <= data_in;
			if (data_in == bfw_pkg::NewlineByte) begin
				nl_count_q <= nl_count_q + AddrW'(1);
			end
		end else if (do_pop) begin
			rd_ptr_q <= next_pos(rd_ptr_q, active);
			count_q  <= count_q - AddrW'(1);
			if (oldest_q == bfw_pkg::NewlineByte && nl_count_q != '0) begin
				nl_count_q <= nl_count_q - AddrW'(1);
			end
		end
	end

	// Head byte copy: set on push into an empty store, refilled after pop
	always_ff @(posedge clk) begin
		if (do_push && count_q == '0) begin
			oldest_q <= data_in;
		end else if (cmd.load_oldest) begin
			oldest_q <= rd_data_q;
		end
	end

	// Peek walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peek_ptr_q <= '0;
			remain_q   <= '0;
		end else if (cmd.peek_start) begin
			peek_ptr_q <= next_pos(rd_ptr_q, active);
			remain_q   <= peek_len;
		end else if (cmd.emit_peek) begin
			peek_ptr_q <= next_pos(peek_ptr_q, active);
			remain_q   <= remain_q - AddrW'(1);
		end
	end

	// Hold the single-result fields of push, pop, clear and empty peek
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			res_acc_q   <= can_push;
			res_data_q  <= '0;
			res_valid_q <= 1'b0;
		end else if (cmd.pop) begin
			res_acc_q   <= do_pop;
			res_data_q  <= do_pop ? oldest_q : 8'd0;
			res_valid_q <= do_pop;
		end else if (cmd.clear || cmd.peek_none) begin
			res_acc_q   <= 1'b1;
			res_data_q  <= '0;
			res_valid_q <= 1'b0;
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output beat payload with status taken from the current store state
	always_ff @(posedge clk) begin
		if (load_out) begin
			accepted    <= cmd.emit_peek ? 1'b1 : res_acc_q;
			data_out    <= cmd.emit_peek ? rd_data_q : res_data_q;
			data_valid  <= cmd.emit_peek ? 1'b1 : res_valid_q;
			last        <= cmd.emit_peek ? status.peek_last : 1'b1;
			fill_count  <= 6'(count_q);
			full_res    <= (count_ext == (active - CmpW'(1)));
			empty_res   <= (count_q == '0);
			high_water  <= ((CmpW + 2)'(count_q) >= high_mark);
			low_water   <= (count_ext <= (active >> 2));
			has_line    <= (nl_count_q != '0);
			oldest_byte <= (count_q != '0) ? oldest_q : 8'd0;
			newest_byte <= (count_q != '0) ? last_pushed_q : 8'd0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- hdl/byte_fifo_with_watermarks.sv -----
`timescale 1ns / 1ps
// Top level of the byte FIFO with watermarks: register port, sequencer and datapath.
// Depends on bfw_pkg, bfw_ctrl and bfw_datapath.

// Circular byte FIFO of up to 64 entries whose active size is set by the ring_size register
// (byte address 0, clamped to 3..64; capacity is one less). A write to ring_size empties the
// store. One request is worked at a time: push and clear pass through the result register
// and then the output register; a pop also passes through a registered store read that
// refreshes the head byte (skipped when the store is empty), and a peek returns its bytes
// from registered store reads. The next request is taken once the final result is in the
// output register, so a waiting result does not hold off input. Stalls on the output hold
// the sequencer until the output register is free.
module byte_fifo_with_watermarks (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [7:0]  data_in,
	input  logic [5:0]  peek_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        accepted,
	output logic [7:0]  data_out,
	output logic        data_valid,
	output logic        last,
	output logic [5:0]  fill_count,
	output logic        full_res,
	output logic        empty_res,
	output logic        high_water,
	output logic        low_water,
	output logic        has_line,
	output logic [7:0]  oldest_byte,
	output logic [7:0]  newest_byte
);

	bfw_pkg::cmd_t    cmd;
	bfw_pkg::status_t status;
	logic             cfg_wr;
	logic [bfw_pkg::RingSizeW-1:0] ring_size;

	// Register port: one word register, decoded on the word index
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bfw_pkg::RegRingSize);
	assign prdata = (paddr[2] == bfw_pkg::RegRingSize) ? 32'(ring_size) : 32'd0;

	bfw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.status   (status),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	bfw_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.data_in       (data_in),
		.peek_count    (peek_count),
		.cfg_wr        (cfg_wr),
		.cfg_ring_size (pwdata[bfw_pkg::RingSizeW-1:0]),
		.ring_size     (ring_size),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.accepted      (accepted),
		.data_out      (data_out),
		.data_valid    (data_valid),
		.last          (last),
		.fill_count    (fill_count),
		.full_res      (full_res),
		.empty_res     (empty_res),
		.high_water    (high_water),
		.low_water     (low_water),
		.has_line      (has_line),
		.oldest_byte   (oldest_byte),
		.newest_byte   (newest_byte)
	);

	// One request at a time: input is held off right after a beat is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken on two consecutive cycles");

	// Full and empty never coincide, the active size is at least three
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(full_res && empty_res))
		else $error("full and empty reported together");

	// A result that carries a byte was an accepted operation
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && data_valid) |-> accepted)
		else $error("data valid on a refused request");

	// Only peek results come before the final one, and each carries a byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (data_valid && !empty_res))
		else $error("non-final result without a stored byte");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench for byte_fifo_with_watermarks: directed and random request streams, every result
// beat checked field by field against a FIFO model kept in the bench. Depends on bfw_pkg.
module tb_top;

	// One result beat as the block reports it
	typedef struct packed {
		logic       acc;
		logic [7:0] data;
		logic       dv;
		logic       lst;
		logic [5:0] fill;
		logic       full;
		logic       empty;
		logic       hw;
		logic       lw;
		logic       nl;
		logic [7:0] oldest;
		logic [7:0] newest;
	} fifo_beat_t;

	localparam logic [2:0] RingSizeAddr = {bfw_pkg::RegRingSize, 2'b00};
	localparam int         RunLimitNs   = 20_000_000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  req_type;
	logic [7:0]  data_in;
	logic [5:0]  peek_count;
	logic        out_valid;
	logic        out_stall;
	logic        accepted;
	logic [7:0]  data_out;
	logic        data_valid;
	logic        last;
	logic [5:0]  fill_count;
	logic        full_res;
	logic        empty_res;
	logic        high_water;
	logic        low_water;
	logic        has_line;
	logic [7:0]  oldest_byte;
	logic [7:0]  newest_byte;

	// FIFO model state and the beats still owed by the block
	logic [7:0]  ring_mem [bfw_pkg::Depth];
	int unsigned head_pos;
	int unsigned tail_pos;
	int unsigned held_bytes;
	int unsigned newline_bytes;
	logic [7:0]  last_in_byte;
	logic [6:0]  ring_reg;
	fifo_beat_t  awaited_beats [$];

	int error_count = 0;
	int gap_pct     = 0;
	int stall_pct   = 0;

	byte_fifo_with_watermarks DUT (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Stop a hung run
	initial begin : run_limit
		#(RunLimitNs);
		$display("CHECK FAILED");
		$finish;
	end

	// Idle length: none, mostly short, a few long
	function automatic int pick_idle(int pct);
		if (pct == 0 || $urandom_range(99) >= pct) return 0;
		if ($urandom_range(99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int unsigned active_span();
		if (ring_reg < bfw_pkg::MinRing) return bfw_pkg::MinRing;
		if (ring_reg > bfw_pkg::Depth) return bfw_pkg::Depth;
		return ring_reg;
	endfunction

	function automatic int unsigned step_pos(int unsigned p);
		return (p + 1 >= active_span()) ? 0 : p + 1;
	endfunction

	function automatic void empty_ring();
		foreach (ring_mem[i]) ring_mem[i] = 8'h00;
		head_pos      = 0;
		tail_pos      = 0;
		held_bytes    = 0;
		newline_bytes = 0;
	endfunction

	// Build a beat from the current model state
	function automatic fifo_beat_t status_beat(logic acc, logic [7:0] d, logic dv, logic lst);
		fifo_beat_t  b;
		int unsigned span;
		span     = active_span();
		b.acc    = acc;
		b.data   = d;
		b.dv     = dv;
		b.lst    = lst;
		b.fill   = 6'(held_bytes);
		b.full   = (held_bytes == span - 1);
		b.empty  = (held_bytes == 0);
		b.hw     = (held_bytes >= span * 3 / 4);
		b.lw     = (held_bytes <= span / 4);
		b.nl     = (newline_bytes > 0);
		b.oldest = (held_bytes > 0) ? ring_mem[head_pos] : 8'h00;
		b.newest = (held_bytes > 0) ? last_in_byte : 8'h00;
		return b;
	endfunction

	// Advance the model by one request and queue the beats it owes
	function automatic void apply_request(bfw_pkg::req_t r, logic [7:0] d, logic [5:0] n);
		int unsigned take;
		int unsigned p;
		logic [7:0]  v;
		case (r)
		bfw_pkg::REQ_PUSH: begin
			if (held_bytes < active_span() - 1) begin
				ring_mem[tail_pos] = d;
				tail_pos = step_pos(tail_pos);
				held_bytes++;
				if (d == bfw_pkg::NewlineByte) newline_bytes++;
				last_in_byte = d;
				awaited_beats.push_back(status_beat(1'b1, 8'h00, 1'b0, 1'b1));
			end else begin
				awaited_beats.push_back(status_beat(1'b0, 8'h00, 1'b0, 1'b1));
			end
		end
		bfw_pkg::REQ_POP: begin
			if (held_bytes > 0) begin
				v = ring_mem[head_pos];
				head_pos = step_pos(head_pos);
				held_bytes--;
				if (v == bfw_pkg::NewlineByte && newline_bytes > 0) newline_bytes--;
				awaited_beats.push_back(status_beat(1'b1, v, 1'b1, 1'b1));
			end else begin
				awaited_beats.push_back(status_beat(1'b0, 8'h00, 1'b0, 1'b1));
			end
		end
		bfw_pkg::REQ_PEEK: begin
			take = (n < held_bytes) ? n : held_bytes;
			p    = head_pos;
			if (take == 0) awaited_beats.push_back(status_beat(1'b1, 8'h00, 1'b0, 1'b1));
			for (int k = 0; k < take; k++) begin
				awaited_beats.push_back(status_beat(1'b1, ring_mem[p], 1'b1, k + 1 == take));
				p = step_pos(p);
			end
		end
		bfw_pkg::REQ_CLEAR: begin
			empty_ring();
			awaited_beats.push_back(status_beat(1'b1, 8'h00, 1'b0, 1'b1));
		end
		endcase
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endfunction

	// Compare each accepted result beat with the oldest awaited one
	always @(posedge clk) begin : result_check
		fifo_beat_t want_beat;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_beats.size() == 0) begin
				$error("unexpected result beat: data_out=%0h last=%0b", data_out, last);
				error_count++;
			end else begin
				want_beat = awaited_beats.pop_front();
				check_field("accepted", want_beat.acc, accepted);
				check_field("data_out", want_beat.data, data_out);
				check_field("data_valid", want_beat.dv, data_valid);
				check_field("last", want_beat.lst, last);
				check_field("fill_count", want_beat.fill, fill_count);
				check_field("full_res", want_beat.full, full_res);
				check_field("empty_res", want_beat.empty, empty_res);
				check_field("high_water", want_beat.hw, high_water);
				check_field("low_water", want_beat.lw, low_water);
				check_field("has_line", want_beat.nl, has_line);
				check_field("oldest_byte", want_beat.oldest, oldest_byte);
				check_field("newest_byte", want_beat.newest, newest_byte);
			end
		end
	end

	// Hold off the result side at random
	initial begin : stall_driver
		int len;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			len = pick_idle(stall_pct);
			if (len > 0) begin
				out_stall <= 1'b1;
				repeat (len) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Send one request beat; valid stays high when the next one follows at once
	task automatic send_request(bfw_pkg::req_t r, logic [7:0] d, logic [5:0] n);
		int gap;
		gap = pick_idle(gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= r;
		data_in    <= d;
		peek_count <= n;
		do @(posedge clk); while (in_stall);
		apply_request(r, d, n);
	endtask

	// Drop valid and wait until every owed beat has come back
	task automatic wait_all_results();
		in_valid <= 1'b0;
		while (awaited_beats.size() != 0) @(posedge clk);
	endtask

	// Write ring_size, then read it back; only while the block is idle
	task automatic write_ring_size(logic [6:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= RingSizeAddr;
		pwdata  <= {25'd0, v};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		ring_reg = v;
		empty_ring();
		pwrite  <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field("ring_size", {25'd0, v}, prdata);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Push, peek and pop at the reset size, byte and count extremes, empty cases
	task automatic test_basic_ops();
		gap_pct   = 0;
		stall_pct = 0;
		send_request(bfw_pkg::REQ_PUSH, 8'h00, 6'd0);
		send_request(bfw_pkg::REQ_PUSH, 8'hFF, 6'd63);
		send_request(bfw_pkg::REQ_PUSH, bfw_pkg::NewlineByte, 6'd0);
		// ask for more than is stored, then part, then nothing
		send_request(bfw_pkg::REQ_PEEK, 8'h00, 6'd63);
		send_request(bfw_pkg::REQ_PEEK, 8'hFF, 6'd2);
		send_request(bfw_pkg::REQ_PEEK, 8'h00, 6'd0);
		send_request(bfw_pkg::REQ_POP, 8'h00, 6'd0);
		send_request(bfw_pkg::REQ_POP, 8'h00, 6'd0);
		send_request(bfw_pkg::REQ_POP, 8'h00, 6'd0);
		// underflow, then peek of an empty store
		send_request(bfw_pkg::REQ_POP, 8'hFF, 6'd63);
		send_request(bfw_pkg::REQ_PEEK, 8'h00, 6'd5);
		wait_all_results();
	endtask

	// Smallest ring: overflow, clear, wrap, and a size below the legal range
	task automatic test_small_ring();
		gap_pct   = 30;
		stall_pct = 30;
		write_ring_size(7'd3);
		send_request(bfw_pkg::REQ_PUSH, 8'hA5, 6'd0);
		send_request(bfw_pkg::REQ_PUSH, 8'h5A, 6'd0);
		send_request(bfw_pkg::REQ_PUSH, 8'h3C, 6'd0);
		send_request(bfw_pkg::REQ_PEEK, 8'h00, 6'd2);
		send_request(bfw_pkg::REQ_CLEAR, 8'hFF, 6'd63);
		send_request(bfw_pkg::REQ_POP, 8'h00, 6'd0);
		wait_all_results();
		write_ring_size(7'd0);
		send_request(bfw_pkg::REQ_PUSH, bfw_pkg::NewlineByte, 6'd0);
		send_request(bfw_pkg::REQ_PUSH, bfw_pkg::NewlineByte, 6'd0);
		send_request(bfw_pkg::REQ_POP, 8'h00, 6'd0);
		send_request(bfw_pkg::REQ_PUSH, 8'h11, 6'd0);
		send_request(bfw_pkg::REQ_PEEK, 8'h00, 6'd3);
		wait_all_results();
	endtask

	// One ring setting with a random mix of requests
	task automatic run_random_phase(logic [6:0] ring, int items, int push_pct, int clear_pct,
			int gaps, int stalls);
		bfw_pkg::req_t r;
		int            pick;
		logic [7:0]    d;
		logic [5:0]    n;
		write_ring_size(ring);
		gap_pct   = gaps;
		stall_pct = stalls;
		for (int i = 0; i < items; i++) begin
			pick = $urandom_range(99);
			if (pick < clear_pct) r = bfw_pkg::REQ_CLEAR;
			else if (pick < clear_pct + 12) r = bfw_pkg::REQ_PEEK;
			else if ($urandom_range(99) < push_pct) r = bfw_pkg::REQ_PUSH;
			else r = bfw_pkg::REQ_POP;
			d = ($urandom_range(7) == 0) ? bfw_pkg::NewlineByte : 8'($urandom);
			n = ($urandom_range(5) == 0) ? 6'($urandom) : 6'($urandom_range(8));
			send_request(r, d, n);
		end
		wait_all_results();
	endtask

	task automatic test_random();
		// fill the largest ring to the top, size written above range
		run_random_phase(7'd127, 80, 95, 0, 15, 25);
		run_random_phase(7'd5, 18, 50, 5, 0, 0);
		run_random_phase(7'd17, 22, 60, 3, 40, 10);
		run_random_phase(7'd1, 10, 55, 5, 10, 50);
		run_random_phase(7'($urandom_range(3, 64)), 18, 50, 3, 25, 25);
	endtask

	initial begin : test_sequence
		arst_n     <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= RingSizeAddr;
		pwdata     <= '0;
		in_valid   <= 1'b0;
		req_type   <= bfw_pkg::REQ_PUSH;
		data_in    <= 8'h00;
		peek_count <= 6'd0;
		ring_reg     = bfw_pkg::RingSizeReset;
		last_in_byte = 8'h00;
		empty_ring();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_small_ring();
		test_random();
		wait_all_results();
		// leave room for any stray beat
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
hdl/bfw_pkg.sv
hdl/bfw_ctrl.sv
hdl/bfw_datapath.sv
hdl/byte_fifo_with_watermarks.sv
dv/tb_top.sv
